// ----- rtl/tdtod_pkg.sv -----
`timescale 1ns / 1ps

package tdtod_pkg;

    localparam int TICKS_PER_PERIOD_DEF = 15625;
    localparam int MS_PER_TICK_DEF      = 4;

    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int MS_W   = 32;
    localparam int CMD_W  = 2;

    localparam int HOUR_MOD = 24;
    localparam int MIN_MOD  = 60;
    localparam int SEC_MOD  = 60;
    localparam int SEC_STEP = 8;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [HOUR_W-1:0] set_hour;
        logic [MIN_W-1:0]  set_minute;
        logic [SEC_W-1:0]  set_second;
        logic [MS_W-1:0]   since_ms;
    } cmd_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [MS_W-1:0]   ms_now;
        logic [MS_W-1:0]   elapsed_ms;
    } res_t;

    typedef struct packed {
        logic adv;
        logic load;
    } cell_ctrl_t;

endpackage

// ----- rtl/tdtod_cell.sv -----
`timescale 1ns / 1ps

module tdtod_cell #(
    parameter int W       = 6,
    parameter int MODULUS = 60
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tdtod_pkg::cell_ctrl_t ctrl,
    input  logic [W-1:0]          inc,
    input  logic [W-1:0]          load_val,
    output logic [W-1:0]          value,
    output logic                  carry
);

    localparam logic [W-1:0] MAX_VAL = W'(MODULUS - 1);
    localparam logic [W:0]   MOD_EXT = (W + 1)'(MODULUS);

    logic [W-1:0] value_reg;
    logic [W-1:0] value_next;
    logic [W:0]   sum;
    logic [W-1:0] wrapped;

    always_comb
    begin
        sum     = {1'b0, value_reg} + {1'b0, inc};
        carry   = 1'b0;
        wrapped = sum[W-1:0];
        if (sum >= MOD_EXT)
        begin
            carry   = 1'b1;
            wrapped = W'(sum - MOD_EXT);
        end

        value_next = value_reg;
        if (ctrl.load)
        begin
            value_next = (load_val > MAX_VAL) ? MAX_VAL : load_val;
        end
        else if (ctrl.adv)
        begin
            value_next = wrapped;
        end
        else
        begin
            carry = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_next;

endmodule

// ----- rtl/tdtod_prescale.sv -----
`timescale 1ns / 1ps

module tdtod_prescale #(
    parameter int TICKS_PER_PERIOD = tdtod_pkg::TICKS_PER_PERIOD_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic tick,
    output logic step
);

    localparam int PW = $clog2(TICKS_PER_PERIOD);
    localparam int Q  = TICKS_PER_PERIOD / 8;
    localparam int H  = TICKS_PER_PERIOD / 2;

    localparam logic [PW-1:0] LAST = PW'(TICKS_PER_PERIOD - 1);
    localparam logic [PW-1:0] P1   = PW'(Q);
    localparam logic [PW-1:0] P2   = PW'(2 * Q);
    localparam logic [PW-1:0] P3   = PW'(3 * Q);
    localparam logic [PW-1:0] P4   = PW'(4 * Q);
    localparam logic [PW-1:0] P5   = PW'(H + Q);
    localparam logic [PW-1:0] P6   = PW'(H + 2 * Q);
    localparam logic [PW-1:0] P7   = PW'(H + 3 * Q);

    logic [PW-1:0] count_reg;
    logic [PW-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (tick)
        begin
            count_next = (count_reg == LAST) ? '0 : count_reg + PW'(1);
        end
        // eight 8 s steps per period
        step = tick && ((count_next == '0) || (count_next == P1) || (count_next == P2)
            || (count_next == P3) || (count_next == P4) || (count_next == P5)
            || (count_next == P6) || (count_next == P7));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/tick_driven_time_of_day_clock.sv -----
`timescale 1ns / 1ps

// Time-of-day clock advanced by timer ticks.
// Command channel (cmd_valid / cmd_stall / cmd): each transaction is a tick,
// a set of hour/minute/second (out-of-range values clamp), or a read (any other code).
// A tick adds MS_PER_TICK to the millisecond count and steps a prescaler;
// at eight points per TICKS_PER_PERIOD ticks the clock gains 8 s, rippling
// through the second, minute and hour cells within the same cycle.
// Result channel (res_valid / res_stall / res): one transaction per command,
// giving the time after it, the millisecond count and the count minus
// since_ms.
// The result is registered and appears in the cycle after its command is taken;
// throughput is one command per cycle while results are not stalled, set by the
// single output register. A stalled result holds; cmd_stall is raised only
// while a result is held and stalled, so a new command is taken in the cycle the held result leaves.
// Reset clears the time, millisecond count, prescaler and result valid.

module tick_driven_time_of_day_clock #(
    parameter int TICKS_PER_PERIOD = tdtod_pkg::TICKS_PER_PERIOD_DEF,
    parameter int MS_PER_TICK      = tdtod_pkg::MS_PER_TICK_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  tdtod_pkg::cmd_t cmd,
    output logic            res_valid,
    input  logic            res_stall,
    output tdtod_pkg::res_t res
);

    localparam int MS_W = tdtod_pkg::MS_W;

    logic                          accept;
    logic                          tick;
    logic                          step;
    tdtod_pkg::cell_ctrl_t         ctrl;
    logic [tdtod_pkg::SEC_W-1:0]   sec_val;
    logic [tdtod_pkg::MIN_W-1:0]   min_val;
    logic [tdtod_pkg::HOUR_W-1:0]  hour_val;
    logic                          sec_carry;
    logic                          min_carry;
    logic                          hour_carry;
    logic [MS_W-1:0]               millis_reg;
    logic [MS_W-1:0]               millis_next;
    logic                          res_valid_reg;
    logic                          res_valid_next;
    tdtod_pkg::res_t               res_reg;

    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        tick      = 1'b0;
        ctrl.load = 1'b0;
        case (cmd.command)
            tdtod_pkg::CMD_TICK: tick      = accept;
            tdtod_pkg::CMD_SET:  ctrl.load = accept;
            tdtod_pkg::CMD_READ: ;
            default:             ;
        endcase
        ctrl.adv = step;
    end

    tdtod_prescale #(
        .TICKS_PER_PERIOD(TICKS_PER_PERIOD)
    ) u_prescale (
        .clk  (clk),
        .rst_n(rst_n),
        .tick (tick),
        .step (step)
    );

    tdtod_cell #(
        .W      (tdtod_pkg::SEC_W),
        .MODULUS(tdtod_pkg::SEC_MOD)
    ) u_sec (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .inc     (tdtod_pkg::SEC_W'(tdtod_pkg::SEC_STEP)),
        .load_val(cmd.set_second),
        .value   (sec_val),
        .carry   (sec_carry)
    );

    tdtod_cell #(
        .W      (tdtod_pkg::MIN_W),
        .MODULUS(tdtod_pkg::MIN_MOD)
    ) u_min (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .inc     ({{(tdtod_pkg::MIN_W - 1){1'b0}}, sec_carry}),
        .load_val(cmd.set_minute),
        .value   (min_val),
        .carry   (min_carry)
    );

    // hour carry-out wraps the day and goes nowhere
    tdtod_cell #(
        .W      (tdtod_pkg::HOUR_W),
        .MODULUS(tdtod_pkg::HOUR_MOD)
    ) u_hour (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .inc     ({{(tdtod_pkg::HOUR_W - 1){1'b0}}, min_carry}),
        .load_val(cmd.set_hour),
        .value   (hour_val),
        .carry   (hour_carry)
    );

    always_comb
    begin
        millis_next    = tick ? millis_reg + MS_W'(MS_PER_TICK) : millis_reg;
        res_valid_next = accept || (res_valid_reg && res_stall) || (hour_carry && 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            millis_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            millis_reg    <= millis_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg.hour       <= hour_val;
            res_reg.minute     <= min_val;
            res_reg.second     <= sec_val;
            res_reg.ms_now     <= millis_next;
            res_reg.elapsed_ms <= millis_next - cmd.since_ms;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- rtl/tdtod_checker.sv -----
`timescale 1ns / 1ps

module tdtod_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            cmd_valid,
    input logic            cmd_stall,
    input tdtod_pkg::cmd_t cmd,
    input logic            res_valid,
    input logic            res_stall,
    input tdtod_pkg::res_t res
);

    logic acc;
    assign acc = cmd_valid && !cmd_stall;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> res_valid && (res.elapsed_ms == res.ms_now - $past(cmd.since_ms)))
        else $error("result missing or elapsed_ms wrong");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.hour < tdtod_pkg::HOUR_W'(tdtod_pkg::HOUR_MOD))
            && (res.minute < tdtod_pkg::MIN_W'(tdtod_pkg::MIN_MOD))
            && (res.second < tdtod_pkg::SEC_W'(tdtod_pkg::SEC_MOD)))
        else $error("time of day out of range");

    a_set_load: assert property (@(posedge clk) disable iff (!rst_n)
        acc && (cmd.command == tdtod_pkg::CMD_SET)
            && (cmd.set_hour < tdtod_pkg::HOUR_W'(tdtod_pkg::HOUR_MOD))
            && (cmd.set_minute < tdtod_pkg::MIN_W'(tdtod_pkg::MIN_MOD))
            && (cmd.set_second < tdtod_pkg::SEC_W'(tdtod_pkg::SEC_MOD))
        |=> (res.hour == $past(cmd.set_hour)) && (res.minute == $past(cmd.set_minute))
            && (res.second == $past(cmd.set_second)))
        else $error("set transaction not loaded");

endmodule

bind tick_driven_time_of_day_clock tdtod_checker u_tdtod_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
);

// ----- tb/tick_driven_time_of_day_clock_tb.sv -----
`timescale 1ns / 1ps

module tick_driven_time_of_day_clock_tb;

    localparam logic [tdtod_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int STEP_SPACING = tdtod_pkg::TICKS_PER_PERIOD_DEF / 8;
    localparam int HALF_PERIOD  = tdtod_pkg::TICKS_PER_PERIOD_DEF / 2;

    logic            clk;
    logic            rst_n;
    logic            cmd_valid;
    logic            cmd_stall;
    tdtod_pkg::cmd_t cmd;
    logic            res_valid;
    logic            res_stall = 1'b0;
    tdtod_pkg::res_t res;

    // predicted clock state
    int                          prescale;
    logic [tdtod_pkg::MS_W-1:0]  millis;
    int                          tod_hour;
    int                          tod_minute;
    int                          tod_second;

    tdtod_pkg::res_t expected_times[$];
    int              mismatches;
    bit              failed;
    int              burst_left;
    int              stall_kind = 0;
    int              stall_left = 0;

    tick_driven_time_of_day_clock u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic bit is_step_point(input int count);
        if (count % STEP_SPACING == 0 && count / STEP_SPACING <= 4)
            return 1'b1;
        if (count > HALF_PERIOD && (count - HALF_PERIOD) % STEP_SPACING == 0 &&
            (count - HALF_PERIOD) / STEP_SPACING >= 1 &&
            (count - HALF_PERIOD) / STEP_SPACING <= 3)
            return 1'b1;
        return 1'b0;
    endfunction

    task automatic gain_eight_seconds();
        tod_second += tdtod_pkg::SEC_STEP;
        if (tod_second >= tdtod_pkg::SEC_MOD)
        begin
            tod_second -= tdtod_pkg::SEC_MOD;
            tod_minute++;
        end
        if (tod_minute >= tdtod_pkg::MIN_MOD)
        begin
            tod_minute -= tdtod_pkg::MIN_MOD;
            tod_hour++;
        end
        if (tod_hour >= tdtod_pkg::HOUR_MOD)
            tod_hour -= tdtod_pkg::HOUR_MOD;
    endtask

    task automatic apply_command(input tdtod_pkg::cmd_t c, output tdtod_pkg::res_t r);
        case (c.command)
            tdtod_pkg::CMD_TICK:
            begin
                millis = millis + tdtod_pkg::MS_W'(tdtod_pkg::MS_PER_TICK_DEF);
                prescale++;
                if (prescale >= tdtod_pkg::TICKS_PER_PERIOD_DEF)
                    prescale = 0;
                if (is_step_point(prescale))
                    gain_eight_seconds();
            end
            tdtod_pkg::CMD_SET:
            begin
                tod_hour   = (c.set_hour > tdtod_pkg::HOUR_MOD - 1) ?
                             tdtod_pkg::HOUR_MOD - 1 : int'(c.set_hour);
                tod_minute = (c.set_minute > tdtod_pkg::MIN_MOD - 1) ?
                             tdtod_pkg::MIN_MOD - 1 : int'(c.set_minute);
                tod_second = (c.set_second > tdtod_pkg::SEC_MOD - 1) ?
                             tdtod_pkg::SEC_MOD - 1 : int'(c.set_second);
            end
            default: ;
        endcase
        r.hour       = tdtod_pkg::HOUR_W'(tod_hour);
        r.minute     = tdtod_pkg::MIN_W'(tod_minute);
        r.second     = tdtod_pkg::SEC_W'(tod_second);
        r.ms_now     = millis;
        r.elapsed_ms = millis - c.since_ms;
    endtask

    function automatic tdtod_pkg::cmd_t make_cmd(input logic [tdtod_pkg::CMD_W-1:0] op,
                                                 input int h, input int m, input int s,
                                                 input logic [tdtod_pkg::MS_W-1:0] since);
        tdtod_pkg::cmd_t c;
        c.command    = op;
        c.set_hour   = tdtod_pkg::HOUR_W'(h);
        c.set_minute = tdtod_pkg::MIN_W'(m);
        c.set_second = tdtod_pkg::SEC_W'(s);
        c.since_ms   = since;
        return c;
    endfunction

    function automatic logic [tdtod_pkg::MS_W-1:0] pick_since_mark();
        case ($urandom_range(0, 5))
            0, 1: return tdtod_pkg::MS_W'($urandom);
            2: return millis - tdtod_pkg::MS_W'($urandom_range(0, 2000));
            3: return millis + tdtod_pkg::MS_W'($urandom_range(1, 2000));
            4: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic tdtod_pkg::cmd_t random_cmd();
        int pick;
        tdtod_pkg::cmd_t c;
        pick = $urandom_range(0, 99);
        c = make_cmd(tdtod_pkg::CMD_TICK, $urandom, $urandom, $urandom, pick_since_mark());
        if (pick >= 55 && pick < 70)
        begin
            c.command = tdtod_pkg::CMD_SET;
            if ($urandom_range(0, 1))
            begin
                c.set_hour   = tdtod_pkg::HOUR_W'($urandom_range(0, tdtod_pkg::HOUR_MOD - 1));
                c.set_minute = tdtod_pkg::MIN_W'($urandom_range(0, tdtod_pkg::MIN_MOD - 1));
                c.set_second = tdtod_pkg::SEC_W'($urandom_range(0, tdtod_pkg::SEC_MOD - 1));
            end
        end
        else if (pick >= 70 && pick < 92)
            c.command = tdtod_pkg::CMD_READ;
        else if (pick >= 92)
            c.command = CMD_SPARE;
        return c;
    endfunction

    task automatic send_cmd(input tdtod_pkg::cmd_t c);
        tdtod_pkg::res_t r;
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(posedge clk); while (cmd_stall);
        apply_command(c, r);
        expected_times.push_back(r);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic log_error(input string msg);
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic test_reset_state();
        send_cmd(make_cmd(tdtod_pkg::CMD_READ, 0, 0, 0, '0));
        send_cmd(make_cmd(tdtod_pkg::CMD_READ, 0, 0, 0, '1));
    endtask

    task automatic test_set_and_clamp();
        send_cmd(make_cmd(tdtod_pkg::CMD_SET, 0, 0, 0, '0));
        send_cmd(make_cmd(tdtod_pkg::CMD_SET, 23, 59, 59, '1));
        send_cmd(make_cmd(tdtod_pkg::CMD_TICK, 0, 0, 0, '1));
        send_cmd(make_cmd(tdtod_pkg::CMD_SET, 31, 63, 63, 32'h5555_5555));
        send_cmd(make_cmd(tdtod_pkg::CMD_SET, 24, 60, 60, 32'hAAAA_AAAA));
        send_cmd(make_cmd(tdtod_pkg::CMD_SET, 7, 60, 0, '0));
        send_cmd(make_cmd(tdtod_pkg::CMD_SET, 12, 30, 61, '0));
        send_cmd(make_cmd(tdtod_pkg::CMD_TICK, 31, 63, 63, '0));
        // unused code reads only, set fields ignored
        send_cmd(make_cmd(CMD_SPARE, 31, 63, 63, '1));
        send_cmd(make_cmd(CMD_SPARE, 0, 0, 0, 32'd4));
        send_cmd(make_cmd(tdtod_pkg::CMD_READ, 0, 0, 0, 32'd100));
    endtask

    task automatic test_random_mix();
        int n;
        for (n = 0; n < 1050; n++)
            send_cmd(random_cmd());
    endtask

    // tick-heavy run; loads near a carry just ahead of any step point
    task automatic test_prescale_periods();
        int n;
        int pick;
        for (n = 0; n < 400; n++)
        begin
            pick = $urandom_range(0, 99);
            if (is_step_point((prescale + 6) % tdtod_pkg::TICKS_PER_PERIOD_DEF) && pick < 60)
                send_cmd(make_cmd(tdtod_pkg::CMD_SET,
                                  pick < 30 ? tdtod_pkg::HOUR_MOD - 1
                                            : $urandom_range(0, tdtod_pkg::HOUR_MOD - 2),
                                  pick < 50 ? tdtod_pkg::MIN_MOD - 1
                                            : $urandom_range(0, tdtod_pkg::MIN_MOD - 2),
                                  $urandom_range(tdtod_pkg::SEC_MOD - tdtod_pkg::SEC_STEP,
                                                 tdtod_pkg::SEC_MOD - 1),
                                  pick_since_mark()));
            else if (pick < 2)
                send_cmd(make_cmd(tdtod_pkg::CMD_READ, $urandom, $urandom, $urandom,
                                  pick_since_mark()));
            else
                send_cmd(make_cmd(tdtod_pkg::CMD_TICK, $urandom, $urandom, $urandom,
                                  pick_since_mark()));
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_kind = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 200);
        end
        else
            stall_left--;
        case (stall_kind)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 3) == 0);
            2: res_stall <= ($urandom_range(0, 9) < 7);
            default: res_stall <= ~res_stall;
        endcase
    end

    always @(posedge clk)
    begin
        tdtod_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_times.size() == 0)
                log_error("result transaction with none expected");
            else
            begin
                want = expected_times.pop_front();
                if (res.hour !== want.hour)
                    log_error($sformatf("hour: expected %0d, got %0d", want.hour, res.hour));
                if (res.minute !== want.minute)
                    log_error($sformatf("minute: expected %0d, got %0d",
                                        want.minute, res.minute));
                if (res.second !== want.second)
                    log_error($sformatf("second: expected %0d, got %0d",
                                        want.second, res.second));
                if (res.ms_now !== want.ms_now)
                    log_error($sformatf("ms_now: expected %0d, got %0d",
                                        want.ms_now, res.ms_now));
                if (res.elapsed_ms !== want.elapsed_ms)
                    log_error($sformatf("elapsed_ms: expected %0d, got %0d",
                                        want.elapsed_ms, res.elapsed_ms));
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        cmd        = '0;
        prescale   = 0;
        millis     = '0;
        tod_hour   = 0;
        tod_minute = 0;
        tod_second = 0;
        burst_left = 0;
        mismatches = 0;
        failed     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_state();
        test_set_and_clamp();
        test_random_mix();
        test_prescale_periods();
        cmd_valid <= 1'b0;
        while (expected_times.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (!failed && expected_times.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tdtod_pkg.sv
rtl/tdtod_cell.sv
rtl/tdtod_prescale.sv
rtl/tick_driven_time_of_day_clock.sv
rtl/tdtod_checker.sv
tb/tick_driven_time_of_day_clock_tb.sv
